// ===== rtl/rgb_contrast_stretch_assert.svh =====
// ----------------------------------------------------------------------------
// rgb contrast stretch assertion macros
// shared concurrent assertion forms used by rcs_div and rgb_contrast_stretch
// ----------------------------------------------------------------------------
`ifndef RGB_CONTRAST_STRETCH_ASSERT_SVH
`define RGB_CONTRAST_STRETCH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// types and constants shared by the rgb contrast stretch modules
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int NUM_CHAN  = 3;
    localparam int PIX_W     = 8;
    localparam int NUM_W     = 2 * PIX_W;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] PIX_MAX = '1;
    localparam logic [PIX_W-1:0] PIX_MIN = '0;

    // transaction kind codes
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_MEASURE = 2'd1;
    localparam logic [1:0] KIND_APPLY   = 2'd2;

    typedef logic [PIX_W-1:0]        t_pix;
    typedef t_pix [NUM_CHAN-1:0]     t_pix_vec;

    typedef struct packed {
        logic [1:0] kind;
        t_pix       red_in;
        t_pix       green_in;
        t_pix       blue_in;
    } t_in_item;

    typedef struct packed {
        t_pix red_out;
        t_pix green_out;
        t_pix blue_out;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DELIVER
    } t_state;

    // which value a channel delivers
    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_ZERO,
        SEL_FULL,
        SEL_QUOT
    } t_sel;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        t_pix             den;
    } t_div_req;

endpackage

// ===== rtl/rcs_div.sv =====
// ----------------------------------------------------------------------------
// rcs_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "rgb_contrast_stretch_assert.svh"

module rcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcs_pkg::t_div_req i_req,
    output logic              o_busy,
    output rcs_pkg::t_pix     o_quot
);

    localparam logic [rcs_pkg::CNT_W-1:0] CNT_LAST = rcs_pkg::CNT_W'(rcs_pkg::DIV_STEPS - 1);

    logic                      r_busy;
    logic [rcs_pkg::CNT_W-1:0] r_cnt;
    rcs_pkg::t_pix             r_rem;
    rcs_pkg::t_pix             r_low;
    rcs_pkg::t_pix             r_den;

    logic [rcs_pkg::PIX_W:0]   trial;
    logic [rcs_pkg::PIX_W:0]   diff;
    logic                      ge;
    rcs_pkg::t_pix             n_rem;
    rcs_pkg::t_pix             n_low;
    logic [rcs_pkg::CNT_W-1:0] n_cnt;

    // remainder stays below the divisor, so the trial fits in one extra bit
    always_comb begin
        trial = {r_rem, r_low[rcs_pkg::PIX_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[rcs_pkg::PIX_W-1:0] : trial[rcs_pkg::PIX_W-1:0];
        n_low = {r_low[rcs_pkg::PIX_W-2:0], ge};
        n_cnt = (r_cnt == CNT_LAST) ? '0 : r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= n_cnt;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[rcs_pkg::NUM_W-1:rcs_pkg::PIX_W];
            r_low <= i_req.num[rcs_pkg::PIX_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_low;

    `RCS_ASSERT_IMP(a_cnt_idle, i_clk, i_rst_n, !r_busy, r_cnt == '0, "divider step count not parked")

endmodule

// ===== rtl/rcs_ext.sv =====
// ----------------------------------------------------------------------------
// rcs_ext
// running per-channel minimum and maximum registers
// ----------------------------------------------------------------------------
module rcs_ext (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_update,
    input  rcs_pkg::t_pix_vec i_pix,
    output rcs_pkg::t_pix_vec o_min,
    output rcs_pkg::t_pix_vec o_max
);

    rcs_pkg::t_pix_vec r_min;
    rcs_pkg::t_pix_vec r_max;
    rcs_pkg::t_pix_vec n_min;
    rcs_pkg::t_pix_vec n_max;

    always_comb begin
        for (int c = 0; c < rcs_pkg::NUM_CHAN; c++) begin
            n_min[c] = (i_pix[c] < r_min[c]) ? i_pix[c] : r_min[c];
            n_max[c] = (i_pix[c] > r_max[c]) ? i_pix[c] : r_max[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int c = 0; c < rcs_pkg::NUM_CHAN; c++) begin
                r_min[c] <= rcs_pkg::PIX_MAX;
                r_max[c] <= rcs_pkg::PIX_MIN;
            end
        end else if (i_update) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

// ===== rtl/rgb_contrast_stretch.sv =====
// ----------------------------------------------------------------------------
// rgb_contrast_stretch
// per-channel min-max contrast stretch of an rgb frame
// ----------------------------------------------------------------------------
// usage: the frame is streamed in twice on the input channel. a start
// transaction clears the running extremes (min 255, max 0), each measure
// transaction widens them, each apply transaction yields one stretched pixel
// on the output channel, value floor(255*(p-min)/(max-min)) per channel;
// a flat or unmeasured channel gives its minimum, values outside the range
// saturate to 0 or 255. kind 3 is dropped.
// sequencing: start and measure transactions leave the input unstalled. an
// apply pixel runs eight steps in the three parallel iterative dividers,
// the sequencer then sees them finish and loads the output register; the
// input stays stalled from acceptance of the apply until that load.
// stall: the output sits in a register that still takes new transactions
// behind a waiting result; an apply result that finds it full waits in the
// dividers, and the input stays stalled until the register frees.
// reset: synchronous, active low; clears extremes, sequencer and output valid.
// ----------------------------------------------------------------------------
`include "rgb_contrast_stretch_assert.svh"

module rgb_contrast_stretch (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rcs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rcs_pkg::t_out_item o_out_data
);

    // sequencer
    rcs_pkg::t_state r_state;
    rcs_pkg::t_state n_state;

    // per-channel context latched with an apply transaction
    rcs_pkg::t_sel [rcs_pkg::NUM_CHAN-1:0] r_sel;
    rcs_pkg::t_pix_vec                     r_lo;

    // output register
    logic               r_out_valid;
    logic               n_out_valid;
    rcs_pkg::t_out_item r_out_data;

    logic              in_acc;
    logic              ext_clear;
    logic              ext_update;
    logic              apply_acc;
    logic              out_free;
    logic              load_out;
    rcs_pkg::t_pix_vec pix;
    rcs_pkg::t_pix_vec ch_min;
    rcs_pkg::t_pix_vec ch_max;
    rcs_pkg::t_pix_vec quot;
    rcs_pkg::t_pix_vec res;
    logic [rcs_pkg::NUM_CHAN-1:0]          div_busy;
    rcs_pkg::t_div_req [rcs_pkg::NUM_CHAN-1:0] div_req;
    rcs_pkg::t_sel [rcs_pkg::NUM_CHAN-1:0] sel;
    rcs_pkg::t_pix_vec                     span;
    rcs_pkg::t_pix_vec                     offs;

    // input handshake, only the idle state takes a transaction
    assign o_in_stall = (r_state != rcs_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ext_clear  = in_acc && (i_in_data.kind == rcs_pkg::KIND_START);
    assign ext_update = in_acc && (i_in_data.kind == rcs_pkg::KIND_MEASURE);
    assign apply_acc  = in_acc && (i_in_data.kind == rcs_pkg::KIND_APPLY);

    // channel 0 is red
    assign pix[0] = i_in_data.red_in;
    assign pix[1] = i_in_data.green_in;
    assign pix[2] = i_in_data.blue_in;

    rcs_ext u_ext (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (ext_clear),
        .i_update (ext_update),
        .i_pix    (pix),
        .o_min    (ch_min),
        .o_max    (ch_max)
    );

    // numerator 255*(p-min) as (d<<8)-d, range checks pick the special cases
    always_comb begin
        for (int c = 0; c < rcs_pkg::NUM_CHAN; c++) begin
            offs[c]          = pix[c] - ch_min[c];
            span[c]          = ch_max[c] - ch_min[c];
            div_req[c].start = apply_acc;
            div_req[c].num   = {offs[c], rcs_pkg::PIX_MIN} - {rcs_pkg::PIX_MIN, offs[c]};
            div_req[c].den   = span[c];
            if (ch_max[c] <= ch_min[c]) begin
                sel[c] = rcs_pkg::SEL_LOW;
            end else if (pix[c] <= ch_min[c]) begin
                sel[c] = rcs_pkg::SEL_ZERO;
            end else if (pix[c] >= ch_max[c]) begin
                sel[c] = rcs_pkg::SEL_FULL;
            end else begin
                sel[c] = rcs_pkg::SEL_QUOT;
            end
        end
    end

    // one divider lane per channel, all run in lockstep
    for (genvar g = 0; g < rcs_pkg::NUM_CHAN; g++) begin : g_lane
        rcs_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (div_req[g]),
            .o_busy  (div_busy[g]),
            .o_quot  (quot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (apply_acc) begin
            r_sel <= sel;
            r_lo  <= ch_min;
        end
    end

    // final per-channel value
    always_comb begin
        for (int c = 0; c < rcs_pkg::NUM_CHAN; c++) begin
            unique case (r_sel[c])
                rcs_pkg::SEL_LOW:  res[c] = r_lo[c];
                rcs_pkg::SEL_ZERO: res[c] = rcs_pkg::PIX_MIN;
                rcs_pkg::SEL_FULL: res[c] = rcs_pkg::PIX_MAX;
                rcs_pkg::SEL_QUOT: res[c] = quot[c];
                default:           res[c] = quot[c];
            endcase
        end
    end

    // output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            rcs_pkg::S_IDLE: begin
                if (apply_acc) begin
                    n_state = rcs_pkg::S_CALC;
                end
            end
            rcs_pkg::S_CALC: begin
                if (!div_busy[0]) begin
                    n_state = rcs_pkg::S_DELIVER;
                end
            end
            rcs_pkg::S_DELIVER: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = rcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.red_out   <= res[0];
            r_out_data.green_out <= res[1];
            r_out_data.blue_out  <= res[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RCS_ASSERT_NEXT(a_apply_starts_div, i_clk, i_rst_n, apply_acc, div_busy[0],
        "apply transaction did not start the dividers")
    `RCS_ASSERT_IMP(a_lanes_lockstep, i_clk, i_rst_n, 1'b1,
        (div_busy == '0) || (div_busy == '1), "divider lanes out of step")
    `RCS_ASSERT_IMP(a_deliver_div_done, i_clk, i_rst_n, r_state == rcs_pkg::S_DELIVER,
        !div_busy[0], "result delivered while dividers still busy")

endmodule
